@@ sv/rtcm3_frame_deframer_crc24q_macros.svh @@
// Assertion macros used by the deframer top level.
`ifndef RTCM3_FRAME_DEFRAMER_CRC24Q_MACROS_SVH
`define RTCM3_FRAME_DEFRAMER_CRC24Q_MACROS_SVH
`ifndef ASSERT_OFF
`define RTCM3_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RTCM3_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RTCM3_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RTCM3_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/rtcm3_pkg.sv @@
// Types, constants and the CRC-24Q byte update for the RTCM3 deframer.
package rtcm3_pkg;
	localparam logic [7:0]  PREAMBLE    = 8'hD3;
	localparam logic [23:0] CRC_POLY    = 24'h864CFB;
	localparam logic [1:0]  LEN_HI_MASK = 2'h3;
	localparam int          LEN_W       = 11;
	localparam int          QDEPTH      = 4;
	localparam int          QPTR_W      = $clog2(QDEPTH);

	typedef enum logic [3:0] {
		PH_SEARCH = 4'b0001,
		PH_LEN1   = 4'b0010,
		PH_LEN2   = 4'b0100,
		PH_BODY   = 4'b1000
	} phase_t;

	// One classified frame byte, as handed from the front to the back.
	typedef struct packed {
		logic [7:0]       data;
		logic             first;
		logic             last;
		logic             crc_in;
		logic [LEN_W-1:0] flen;
	} item_t;

	function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] c;
		logic        top;
		c = crc ^ {b, 16'h0000};
		for (int i = 0; i < 8; i++) begin
			top = c[23];
			c = {c[22:0], 1'b0};
			if (top) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction
endpackage

@@ sv/rtcm3_in_if.sv @@
// Input channel: one received byte per transfer.
interface rtcm3_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ sv/rtcm3_out_if.sv @@
// Output channel: one frame byte with its marks and the frame check result per transfer.
interface rtcm3_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_byte;
	logic        first_of_frame;
	logic        last_of_frame;
	logic        crc_good;
	logic [10:0] frame_length;
	modport source (output valid, output frame_byte, output first_of_frame,
		output last_of_frame, output crc_good, output frame_length, input ready);
	modport sink (input valid, input frame_byte, input first_of_frame,
		input last_of_frame, input crc_good, input frame_length, output ready);
endinterface

@@ sv/rtcm3_frame_deframer_crc24q.sv @@
// RTCM3 deframer top level: takes one received byte per transfer and passes every byte of
// a frame through with first and last marks. The parser accepts a byte every cycle while
// its four-entry queue has room, and the CRC stage retires one queued byte per cycle into
// the output register while that register is empty or its transfer completes, so the
// sustained rate is one byte per cycle when the receiver does not stall. An accepted byte
// goes into the queue, then into the output register. Bytes outside a frame that are not
// the preamble 0xD3 are dropped. On the last CRC byte crc_good reports the CRC-24Q check
// over preamble, length and payload, and frame_length gives the total frame size.
`include "rtcm3_frame_deframer_crc24q_macros.svh"
module rtcm3_frame_deframer_crc24q (
	input  logic        clk,
	input  logic        arst_n,
	rtcm3_in_if.sink    rx,
	rtcm3_out_if.source tx
);
	import rtcm3_pkg::*;

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  pop;
	logic  not_empty;
	item_t head;

	rtcm3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	rtcm3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	rtcm3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.tx        (tx)
	);

	`RTCM3_ASSERT_IMP(a_no_push_when_full, clk, arst_n, q_full, !push)
	`RTCM3_ASSERT_IMP(a_good_only_on_last, clk, arst_n, tx.valid && tx.crc_good, tx.last_of_frame)
	`RTCM3_ASSERT_IMP(a_len_only_on_last, clk, arst_n, tx.valid && !tx.last_of_frame, tx.frame_length == '0)
	`RTCM3_ASSERT_IMP(a_len_min, clk, arst_n, tx.valid && tx.last_of_frame, tx.frame_length >= 11'd6)
	`RTCM3_ASSERT_NXT(a_pop_shows, clk, arst_n, pop, tx.valid)
endmodule

@@ sv/rtcm3_front.sv @@
// Frame parser: hunts for the preamble, tracks the length and classifies each frame byte.
module rtcm3_front (
	input  logic            clk,
	input  logic            arst_n,
	rtcm3_in_if.sink        rx,
	input  logic            q_full,
	output logic            push,
	output rtcm3_pkg::item_t push_item
);
	import rtcm3_pkg::*;

	phase_t           phase_q;
	logic [LEN_W-1:0] bytes_left_q;
	logic [LEN_W-1:0] byte_count_q;
	logic             acc;
	logic [LEN_W-1:0] count_inc;

	assign rx.ready  = !q_full;
	assign acc       = rx.valid && rx.ready;
	assign count_inc = byte_count_q + LEN_W'(1);

	always_comb begin
		push_item.data   = rx.rx_byte;
		push_item.first  = 1'b0;
		push_item.last   = 1'b0;
		push_item.crc_in = 1'b1;
		push_item.flen   = '0;
		push           = 1'b0;
		case (phase_q)
			PH_SEARCH: begin
				push_item.first = 1'b1;
				push = acc && (rx.rx_byte == PREAMBLE);
			end
			PH_LEN1, PH_LEN2: begin
				push = acc;
			end
			PH_BODY: begin
				push = acc;
				push_item.crc_in = (bytes_left_q > LEN_W'(3));
				if (bytes_left_q <= LEN_W'(1)) begin
					push_item.last = 1'b1;
					push_item.flen = count_inc;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SEARCH;
			bytes_left_q <= '0;
			byte_count_q <= '0;
		end else if (acc) begin
			case (phase_q)
				PH_SEARCH: begin
					if (rx.rx_byte == PREAMBLE) begin
						phase_q      <= PH_LEN1;
						byte_count_q <= LEN_W'(1);
						bytes_left_q <= '0;
					end
				end
				PH_LEN1: begin
					phase_q      <= PH_LEN2;
					byte_count_q <= count_inc;
					bytes_left_q <= {1'b0, rx.rx_byte[1:0] & LEN_HI_MASK, 8'h00};
				end
				PH_LEN2: begin
					phase_q      <= PH_BODY;
					byte_count_q <= count_inc;
					// Payload length plus the three CRC bytes.
					bytes_left_q <= (bytes_left_q | {3'b000, rx.rx_byte}) + LEN_W'(3);
				end
				PH_BODY: begin
					byte_count_q <= count_inc;
					if (bytes_left_q <= LEN_W'(1)) begin
						phase_q      <= PH_SEARCH;
						bytes_left_q <= '0;
					end else begin
						bytes_left_q <= bytes_left_q - LEN_W'(1);
					end
				end
				default: begin
					phase_q <= PH_SEARCH;
				end
			endcase
		end
	end
endmodule

@@ sv/rtcm3_queue.sv @@
// Short FIFO of classified frame bytes between the parser and the CRC stage.
module rtcm3_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rtcm3_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output rtcm3_pkg::item_t head
);
	import rtcm3_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

@@ sv/rtcm3_back.sv @@
// CRC stage: runs the CRC-24Q, collects the received CRC and drives the output register.
module rtcm3_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  rtcm3_pkg::item_t head,
	output logic             pop,
	rtcm3_out_if.source      tx
);
	import rtcm3_pkg::*;

	logic [23:0]      crc_accum_q;
	logic [23:0]      crc_rcv_q;
	logic [23:0]      crc_base;
	logic [23:0]      crc_rcv_next;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_first_q;
	logic             out_last_q;
	logic             out_good_q;
	logic [LEN_W-1:0] out_len_q;

	// The output register frees up whenever it is empty or its transfer completes.
	assign pop          = not_empty && (!out_valid_q || tx.ready);
	assign crc_base     = head.first ? 24'h000000 : crc_accum_q;
	assign crc_rcv_next = {crc_rcv_q[15:0], head.data};

	assign tx.valid          = out_valid_q;
	assign tx.frame_byte     = out_byte_q;
	assign tx.first_of_frame = out_first_q;
	assign tx.last_of_frame  = out_last_q;
	assign tx.crc_good       = out_good_q;
	assign tx.frame_length   = out_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_accum_q <= '0;
			crc_rcv_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (head.crc_in) begin
					crc_accum_q <= crc_byte(crc_base, head.data);
				end
				if (head.first) begin
					crc_rcv_q <= '0;
				end else if (!head.crc_in) begin
					crc_rcv_q <= crc_rcv_next;
				end
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q  <= head.data;
			out_first_q <= head.first;
			out_last_q  <= head.last;
			out_len_q   <= head.flen;
			out_good_q  <= head.last && (crc_accum_q == crc_rcv_next);
		end
	end
endmodule

@@ tb/sv/rtcm3_frame_deframer_crc24q_tb.sv @@
// Self-checking testbench for the RTCM3 deframer: directed byte table, then random frames and noise.
module rtcm3_frame_deframer_crc24q_tb;
	import rtcm3_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 9;
	// Random bytes spread over the segments, beside the directed rows and the longest frame.
	localparam int RAND_ITEMS   = 240;
	localparam int SEGMENTS     = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_PAYLOAD  = 1023;

	typedef struct packed {
		logic [7:0]       data;
		logic             first;
		logic             last;
		logic             good;
		logic [LEN_W-1:0] flen;
	} frame_beat_t;

	// One directed row: the byte sent and, where typed, the transfer it must cause.
	typedef struct packed {
		logic [7:0]       rx;
		logic             typed;
		logic             res;
		logic             first;
		logic             last;
		logic             good;
		logic [LEN_W-1:0] flen;
	} dir_row_t;

	localparam int DIR_N = 22;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		// Bytes outside a frame are dropped.
		'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
		// The standard empty frame with a good CRC.
		'{8'hD3, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'h47, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'hEA, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'h4B, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 11'd6},
		'{8'h52, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
		// The same empty frame with the last CRC byte damaged.
		'{8'hD3, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'h47, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'hEA, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'h4A, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 11'd6},
		// Reserved length bits set, and a preamble value carried as payload.
		'{8'hD3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'hFC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'hD3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0}
	};

	logic clk;
	logic arst_n;

	rtcm3_in_if  rx_if ();
	rtcm3_out_if tx_if ();

	rtcm3_frame_deframer_crc24q u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if.sink),
		.tx     (tx_if.source)
	);

	// Deframer state as the predictor tracks it.
	phase_t           hunt = PH_SEARCH;
	logic [LEN_W-1:0] bytes_due = '0;
	logic [LEN_W-1:0] byte_cnt = '0;
	logic [23:0]      crc_run = 24'h000000;
	logic [23:0]      crc_rx = 24'h000000;

	frame_beat_t beats_due [$];

	int unsigned errors;
	int unsigned cycles;
	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned hold_reqs;
	int unsigned items_sent;

	// Directed expectation attached to the byte currently offered.
	logic        row_typed;
	logic        row_res;
	frame_beat_t row_beat;

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// Bit-serial CRC-24Q, most significant bit of the byte first.
	function automatic logic [23:0] crc24q_next(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[23] ^ b[i];
			c = {c[22:0], 1'b0} ^ (fb ? CRC_POLY : 24'h000000);
		end
		return c;
	endfunction

	task automatic deframe_predict(input logic [7:0] b, output logic produced,
		output frame_beat_t beat);
		beat = '0;
		beat.data = b;
		produced = 1'b1;
		case (hunt)
			PH_SEARCH: begin
				if (b != PREAMBLE) begin
					produced = 1'b0;
				end else begin
					beat.first = 1'b1;
					crc_run = crc24q_next(24'h000000, b);
					crc_rx = 24'h000000;
					byte_cnt = LEN_W'(1);
					bytes_due = '0;
					hunt = PH_LEN1;
				end
			end
			PH_LEN1: begin
				crc_run = crc24q_next(crc_run, b);
				bytes_due = {1'b0, b[1:0] & LEN_HI_MASK, 8'h00};
				byte_cnt = byte_cnt + LEN_W'(1);
				hunt = PH_LEN2;
			end
			PH_LEN2: begin
				crc_run = crc24q_next(crc_run, b);
				bytes_due = (bytes_due | {3'b000, b}) + LEN_W'(3);
				byte_cnt = byte_cnt + LEN_W'(1);
				hunt = PH_BODY;
			end
			default: begin
				byte_cnt = byte_cnt + LEN_W'(1);
				if (bytes_due > LEN_W'(3)) begin
					crc_run = crc24q_next(crc_run, b);
				end else begin
					crc_rx = {crc_rx[15:0], b};
				end
				if (bytes_due <= LEN_W'(1)) begin
					beat.last = 1'b1;
					beat.good = (crc_run == crc_rx);
					beat.flen = byte_cnt;
					bytes_due = '0;
					hunt = PH_SEARCH;
				end else begin
					bytes_due = bytes_due - LEN_W'(1);
				end
			end
		endcase
	endtask

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		errors++;
		$display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Offers one byte and returns at the edge where the transfer happens.
	task automatic send_byte(input logic [7:0] b, input logic typed, input logic res,
		input frame_beat_t beat);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		row_typed = typed;
		row_res = res;
		row_beat = beat;
		@(posedge clk);
		while (!rx_if.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_frame(input int unsigned plen, input logic corrupt);
		logic [7:0]  fr [$];
		logic [23:0] c;
		logic [31:0] r;
		logic [9:0]  len;
		int unsigned k;
		len = 10'(plen);
		r = $urandom;
		fr.push_back(PREAMBLE);
		fr.push_back({(r[0] ? r[7:2] : 6'h00), len[9:8]});
		fr.push_back(len[7:0]);
		for (k = 0; k < plen; k++) begin
			r = $urandom;
			fr.push_back((r[2:0] == 3'd0) ? PREAMBLE : r[15:8]);
		end
		c = 24'h000000;
		foreach (fr[j]) begin
			c = crc24q_next(c, fr[j]);
		end
		fr.push_back(c[23:16]);
		fr.push_back(c[15:8]);
		fr.push_back(c[7:0]);
		// Damage payload or CRC only, so the frame keeps its length.
		if (corrupt) begin
			k = $urandom_range(3, fr.size() - 1);
			r = $urandom;
			fr[k] = fr[k] ^ (8'h01 << r[2:0]);
		end
		foreach (fr[j]) begin
			send_byte(fr[j], 1'b0, 1'b0, '0);
		end
		items_sent += fr.size();
	endtask

	task automatic send_noise(input int unsigned n);
		logic [31:0] r;
		logic [7:0]  b;
		repeat (n) begin
			r = $urandom;
			b = r[7:0];
			if (b == PREAMBLE) begin
				b = 8'h00;
			end
			send_byte(b, 1'b0, 1'b0, '0);
		end
	endtask

	// Output check first, then prediction for the byte taken at the same edge.
	always @(posedge clk) begin
		logic        produced;
		frame_beat_t beat;
		frame_beat_t want;
		if (arst_n) begin
			if (tx_if.valid && tx_if.ready) begin
				if (beats_due.size() == 0) begin
					report("unexpected transfer", tx_if.frame_byte, 0);
				end else begin
					want = beats_due.pop_front();
					if (tx_if.frame_byte !== want.data) begin
						report("frame_byte", tx_if.frame_byte, want.data);
					end
					if (tx_if.first_of_frame !== want.first) begin
						report("first_of_frame", tx_if.first_of_frame, want.first);
					end
					if (tx_if.last_of_frame !== want.last) begin
						report("last_of_frame", tx_if.last_of_frame, want.last);
					end
					if (tx_if.crc_good !== want.good) begin
						report("crc_good", tx_if.crc_good, want.good);
					end
					if (tx_if.frame_length !== want.flen) begin
						report("frame_length", tx_if.frame_length, want.flen);
					end
				end
			end
			if (rx_if.valid && rx_if.ready) begin
				deframe_predict(rx_if.rx_byte, produced, beat);
				if (row_typed) begin
					produced = row_res;
					beat = row_beat;
				end
				if (produced) begin
					beats_due.push_back(beat);
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int unsigned hold_seen;
		int unsigned hold_left;
		tx_if.ready <= 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				tx_if.ready <= 1'b0;
				hold_left--;
			end else begin
				tx_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		frame_beat_t beat;
		int unsigned seg;
		int unsigned seg_end;
		int unsigned r;
		int unsigned plen;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= 8'h00;
		arst_n = 1'b0;
		row_typed = 1'b0;
		row_res = 1'b0;
		row_beat = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (RESET_CYCLES) begin
			@(posedge clk);
		end
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_N; i++) begin
			beat = '0;
			beat.data = DIR_TAB[i].rx;
			beat.first = DIR_TAB[i].first;
			beat.last = DIR_TAB[i].last;
			beat.good = DIR_TAB[i].good;
			beat.flen = DIR_TAB[i].flen;
			send_byte(DIR_TAB[i].rx, DIR_TAB[i].typed, DIR_TAB[i].res, beat);
		end

		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 47;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 47;
				end
				default: begin
					tx_idle_pct = 7;
					rx_stall_pct = 7;
				end
			endcase
			// The sender keeps offering through the hold-off, so the block backs up.
			if (seg == 4) begin
				hold_reqs++;
			end
			if (seg == 6) begin
				send_frame(MAX_PAYLOAD, 1'b0);
			end
			seg_end = items_sent + RAND_ITEMS / SEGMENTS;
			while (items_sent < seg_end) begin
				r = $urandom_range(0, 99);
				plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
				if (r < 70) begin
					send_frame(plen, 1'b0);
				end else if (r < 85) begin
					send_frame(plen, 1'b1);
				end else begin
					send_noise($urandom_range(1, 4));
				end
			end
		end

		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (beats_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) begin
			@(posedge clk);
		end
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+sv
sv/rtcm3_pkg.sv
sv/rtcm3_in_if.sv
sv/rtcm3_out_if.sv
sv/rtcm3_front.sv
sv/rtcm3_queue.sv
sv/rtcm3_back.sv
sv/rtcm3_frame_deframer_crc24q.sv
tb/sv/rtcm3_frame_deframer_crc24q_tb.sv
